// ===== hdl/dssm_pkg.sv =====
`default_nettype none

package dssm_pkg;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths.
   localparam int VALUE_W  = 32;
   localparam int CFG_W    = 11;
   localparam int STATUS_W = 2;

   // Capacity after reset, before it is limited to the memory depth.
   localparam int CAPACITY_RESET = 1024;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // Request kinds and stack selectors.
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;
   localparam logic SEL_LOW  = 1'b0;
   localparam logic SEL_HIGH = 1'b1;

   // Controller to datapath.
   typedef struct packed {
      logic accept;        // a request beat is taken this cycle
      logic capture_read;  // memory read data is valid this cycle
   } dssm_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pop_ok;  // the selected stack holds at least one element
      logic full;    // the two stacks together fill the capacity
   } dssm_status_type;

endpackage

`default_nettype wire

// ===== hdl/dual_stack_shared_memory_unit.sv =====
// A push or a refused pop gives its result in the cycle after the beat is taken; a pop
// that succeeds goes through the memory read register and then the result register.
// One push or refused pop per cycle while the result register drains; a successful pop
// holds off the next beat while the single registered read port of the slot memory is read.
// Reset clears both stack counts and sets capacity to 1024 (limited to DEPTH); the slot
// memory is not cleared and is ready at once.
`default_nettype none

module dual_stack_shared_memory_unit
   import dssm_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [CFG_W-1:0]   csr_wr_data,   // capacity
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [31:0]        req_tdata,     // [31:0] push_value
   input  wire logic [1:0]         req_tuser,     // [0] req_type, [1] stack_select
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [31:0]             rsp_tdata,     // [31:0] pop_value
   output logic [1:0]              rsp_tuser      // [1:0] status
);

   dssm_cmd_type    cmd;
   dssm_status_type dp_status;

   dssm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_is_pop (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   dssm_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_is_pop  (req_tuser[0]),
      .req_sel     (req_tuser[1]),
      .req_value   (req_tdata),
      .cmd         (cmd),
      .status      (dp_status),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_status  (rsp_tuser),
      .rsp_value   (rsp_tdata)
   );

   // A successful pop holds off the next beat while the memory is read.
   a_pop_blocks: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && (req_tuser[0] == REQ_POP) && dp_status.pop_ok) |=> !req_tready)
      else $error("request taken during a pending memory read");

   // The result register must be empty when read data lands in it.
   a_capture_free: assert property (@(posedge clock) disable iff (reset)
      cmd.capture_read |-> !rsp_tvalid)
      else $error("read data would overwrite a waiting result");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && (req_tuser[0] == REQ_PUSH) && dp_status.full)
      |=> (rsp_tvalid && (rsp_tuser == STATUS_FULL)))
      else $error("push into a full memory not refused");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STATUS_OK)) |-> (rsp_tdata == '0))
      else $error("refused request carries a nonzero value");

endmodule

`default_nettype wire

// ===== hdl/dssm_ram.sv =====
`default_nettype none

module dssm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/dssm_ctrl.sv =====
`default_nettype none

module dssm_ctrl
   import dssm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic            req_is_pop,
   input  wire logic            rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire dssm_status_type status,
   output dssm_cmd_type         cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   // A new beat may enter only when the result register will be free at this edge.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_tvalid || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_is_pop == REQ_POP) && status.pop_ok) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.accept       = accept;
   assign cmd.capture_read = (state_ff == ST_READ);

endmodule

`default_nettype wire

// ===== hdl/dssm_datapath.sv =====
`default_nettype none

module dssm_datapath
   import dssm_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [CFG_W-1:0]    csr_wr_data,
   input  wire logic                req_is_pop,
   input  wire logic                req_sel,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire dssm_cmd_type        cmd,
   output dssm_status_type          status,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [VALUE_W-1:0]       rsp_value
);

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CAP_RST = (CAPACITY_RESET > DEPTH) ? DEPTH : CAPACITY_RESET;

   logic [CNT_W-1:0]      low_count_ff, low_count_in;
   logic [CNT_W-1:0]      high_count_ff, high_count_in;
   logic [CNT_W-1:0]      capacity_ff, capacity_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;

   logic [CNT_W:0]        used;
   logic                  full;
   logic                  pop_ok;
   logic                  do_push;
   logic                  do_pop;
   logic [CNT_W-1:0]      high_push_slot;
   logic [CNT_W-1:0]      high_pop_slot;
   logic                  mem_wr_en;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [DATA_WIDTH-1:0] mem_rd_data;
   logic [VALUE_W-1:0]    read_value;

   assign used   = {1'b0, low_count_ff} + {1'b0, high_count_ff};
   assign full   = (used >= {1'b0, capacity_ff});
   assign pop_ok = (req_sel == SEL_HIGH) ? (high_count_ff != '0) : (low_count_ff != '0);

   assign status.pop_ok = pop_ok;
   assign status.full   = full;

   assign do_push = cmd.accept && (req_is_pop == REQ_PUSH) && !full;
   assign do_pop  = cmd.accept && (req_is_pop == REQ_POP) && pop_ok;

   // The high stack's next free slot sits at capacity - 1 - high_count; its top at capacity - high_count.
   assign high_push_slot = capacity_ff - CNT_W'(1) - high_count_ff;
   assign high_pop_slot  = capacity_ff - high_count_ff;

   assign mem_wr_en   = do_push;
   assign mem_wr_addr = (req_sel == SEL_HIGH) ? high_push_slot[ADDR_W-1:0]
                                              : low_count_ff[ADDR_W-1:0];
   assign mem_wr_data = DATA_WIDTH'(req_value);

   always_comb begin
      logic [CNT_W-1:0] low_top;
      low_top     = low_count_ff - CNT_W'(1);
      mem_rd_addr = (req_sel == SEL_HIGH) ? high_pop_slot[ADDR_W-1:0]
                                          : low_top[ADDR_W-1:0];
   end

   dssm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Popped elements are sign-extended from the stored width when it is narrower, else cut to the low bits.
   generate
      if (DATA_WIDTH >= VALUE_W) begin : g_wide
         assign read_value = mem_rd_data[VALUE_W-1:0];
      end else begin : g_narrow
         assign read_value = {{(VALUE_W - DATA_WIDTH){mem_rd_data[DATA_WIDTH-1]}},
                              mem_rd_data};
      end
   endgenerate

   always_comb begin
      low_count_in  = low_count_ff;
      high_count_in = high_count_ff;
      if (do_push) begin
         if (req_sel == SEL_HIGH) begin
            high_count_in = high_count_ff + CNT_W'(1);
         end else begin
            low_count_in = low_count_ff + CNT_W'(1);
         end
      end else if (do_pop) begin
         if (req_sel == SEL_HIGH) begin
            high_count_in = high_count_ff - CNT_W'(1);
         end else begin
            low_count_in = low_count_ff - CNT_W'(1);
         end
      end
   end

   // Capacity changes only while both stacks are empty; larger values saturate.
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr_en && (low_count_ff == '0) && (high_count_ff == '0)) begin
         if (32'(csr_wr_data) > 32'(DEPTH)) begin
            capacity_in = CNT_W'(DEPTH);
         end else begin
            capacity_in = CNT_W'(csr_wr_data);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (cmd.capture_read) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_value_in  = read_value;
      end else if (cmd.accept && !do_pop) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         if (req_is_pop == REQ_POP) begin
            rsp_status_in = STATUS_EMPTY;
         end else if (full) begin
            rsp_status_in = STATUS_FULL;
         end else begin
            rsp_status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_count_ff  <= '0;
         high_count_ff <= '0;
         capacity_ff   <= CNT_W'(CAP_RST);
         rsp_valid_ff  <= 1'b0;
      end else begin
         low_count_ff  <= low_count_in;
         high_count_ff <= high_count_in;
         capacity_ff   <= capacity_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;

endmodule

`default_nettype wire
